[rtl/bresenham_line_rasterizer_core_macros.svh]
// Assertion macros shared by the rasterizer modules.
`ifndef BRESENHAM_LINE_RASTERIZER_CORE_MACROS_SVH
`define BRESENHAM_LINE_RASTERIZER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BLR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BLR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/blr_pkg.sv]
// Types and constants shared by the line rasterizer modules.
package blr_pkg;

  localparam int COORD_W         = 6;
  localparam int CFG_W           = 7;
  localparam int CFG_IDX_W       = 1;
  localparam int OFFS_W          = 14;
  localparam int COLOUR_W        = 8;
  localparam int ERR_W           = 9;
  localparam int MAX_SIDE        = 64;
  localparam int BYTES_PER_PIXEL = 4;
  localparam int BPP_SHIFT       = $clog2(BYTES_PER_PIXEL);

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SETUP = 3'b010,
    ST_RUN   = 3'b100
  } ctl_state_t;

  typedef struct packed {
    logic load;
    logic setup;
    logic step;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic at_last;
  } dp_sts_t;

endpackage

[rtl/bresenham_line_rasterizer_core.sv]
// Bresenham line rasterizer: one line command in, one beat per pixel out.
// Sequence: capture, set-up, then one step per pixel into the output register.
// A line has n pixels (n = max(|dx|,|dy|)+1, up to 64); stepping holds while the
//   output is stalled, and no new command is taken until the last pixel is stepped.
// Reset: synchronous active-low rst_n idles the sequencer, empties the output
//   register and sets image width and height to 64.
module bresenham_line_rasterizer_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [blr_pkg::COORD_W-1:0]        in_x_start,
  input  logic [blr_pkg::COORD_W-1:0]        in_y_start,
  input  logic [blr_pkg::COORD_W-1:0]        in_x_end,
  input  logic [blr_pkg::COORD_W-1:0]        in_y_end,
  input  logic [blr_pkg::COLOUR_W-1:0]       in_red,
  input  logic [blr_pkg::COLOUR_W-1:0]       in_green,
  input  logic [blr_pkg::COLOUR_W-1:0]       in_blue,
  input  logic [blr_pkg::COLOUR_W-1:0]       in_alpha,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [blr_pkg::COORD_W-1:0]        out_pixel_x,
  output logic [blr_pkg::COORD_W-1:0]        out_pixel_y,
  output logic [blr_pkg::OFFS_W-1:0]         out_byte_offset,
  output logic [blr_pkg::COLOUR_W-1:0]       out_red,
  output logic [blr_pkg::COLOUR_W-1:0]       out_green,
  output logic [blr_pkg::COLOUR_W-1:0]       out_blue,
  output logic [blr_pkg::COLOUR_W-1:0]       out_alpha,
  output logic                               out_in_image,
  output logic                               out_last,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [blr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [blr_pkg::CFG_W-1:0]          cfg_data
);

  blr_pkg::dp_cmd_t cmd;
  blr_pkg::dp_sts_t sts;

  assign cfg_ready = 1'b1;

  blr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  blr_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_x_start      (in_x_start),
    .in_y_start      (in_y_start),
    .in_x_end        (in_x_end),
    .in_y_end        (in_y_end),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .in_alpha        (in_alpha),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_byte_offset (out_byte_offset),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_alpha       (out_alpha),
    .out_in_image    (out_in_image),
    .out_last        (out_last)
  );

endmodule

[rtl/blr_ctrl.sv]
// Sequencer for one line command: capture, set up, step each pixel.
`include "bresenham_line_rasterizer_core_macros.svh"

module blr_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  blr_pkg::dp_sts_t sts,
  output blr_pkg::dp_cmd_t cmd
);

  blr_pkg::ctl_state_t state_r, state_nxt;
  logic                accept;

  assign in_stall = (state_r != blr_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      blr_pkg::ST_IDLE: begin
        cmd.load = accept;
        if (accept) state_nxt = blr_pkg::ST_SETUP;
      end
      blr_pkg::ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = blr_pkg::ST_RUN;
      end
      blr_pkg::ST_RUN: begin
        cmd.step = sts.out_free;
        if (sts.out_free && sts.at_last) state_nxt = blr_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = blr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= blr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `BLR_ASSERT_NEXT(a_accept_to_setup, accept, state_r == blr_pkg::ST_SETUP,
                   "accepted command did not enter setup")
  `BLR_ASSERT_NEXT(a_last_to_idle, cmd.step && sts.at_last, state_r == blr_pkg::ST_IDLE,
                   "last pixel did not return to idle")
  `BLR_ASSERT_SAME(a_step_needs_room, cmd.step, sts.out_free,
                   "step issued while output beat blocked")

endmodule

[rtl/blr_datapath.sv]
// Line set-up, Bresenham stepping, pixel addressing and output register.
`include "bresenham_line_rasterizer_core_macros.svh"

module blr_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  blr_pkg::dp_cmd_t                    cmd,
  output blr_pkg::dp_sts_t                    sts,
  input  logic                                cfg_we,
  input  logic [blr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [blr_pkg::CFG_W-1:0]           cfg_data,
  input  logic [blr_pkg::COORD_W-1:0]         in_x_start,
  input  logic [blr_pkg::COORD_W-1:0]         in_y_start,
  input  logic [blr_pkg::COORD_W-1:0]         in_x_end,
  input  logic [blr_pkg::COORD_W-1:0]         in_y_end,
  input  logic [blr_pkg::COLOUR_W-1:0]        in_red,
  input  logic [blr_pkg::COLOUR_W-1:0]        in_green,
  input  logic [blr_pkg::COLOUR_W-1:0]        in_blue,
  input  logic [blr_pkg::COLOUR_W-1:0]        in_alpha,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [blr_pkg::COORD_W-1:0]         out_pixel_x,
  output logic [blr_pkg::COORD_W-1:0]         out_pixel_y,
  output logic [blr_pkg::OFFS_W-1:0]          out_byte_offset,
  output logic [blr_pkg::COLOUR_W-1:0]        out_red,
  output logic [blr_pkg::COLOUR_W-1:0]        out_green,
  output logic [blr_pkg::COLOUR_W-1:0]        out_blue,
  output logic [blr_pkg::COLOUR_W-1:0]        out_alpha,
  output logic                                out_in_image,
  output logic                                out_last
);

  localparam int CW = blr_pkg::COORD_W;
  localparam int RW = blr_pkg::CFG_W;
  localparam int OW = blr_pkg::OFFS_W;
  localparam int EW = blr_pkg::ERR_W;
  localparam int KW = blr_pkg::COLOUR_W;

  logic [RW-1:0] width_r, height_r;

  logic [CW-1:0] x0_r, y0_r, x1_r, y1_r;
  logic [KW-1:0] red_r, green_r, blue_r, alpha_r;

  logic          steep_r, minor_up_r;
  logic [CW-1:0] major_r, major_end_r, minor_r, major_d_r;
  logic [CW:0]   step_err_r;
  logic signed [EW-1:0] err_r;

  logic          out_valid_r;
  logic [CW-1:0] px_r, py_r;
  logic [OW-1:0] offset_r;
  logic [KW-1:0] ored_r, ogreen_r, oblue_r, oalpha_r;
  logic          inside_r, last_r;

  // set-up
  logic [CW-1:0] dx_abs, dy_abs, a0, b0, a1, b1;
  logic [CW-1:0] maj_s, maj_e, min_s, min_e, min_d;
  logic          steep, swap;

  always_comb begin
    dx_abs = (x0_r > x1_r) ? x0_r - x1_r : x1_r - x0_r;
    dy_abs = (y0_r > y1_r) ? y0_r - y1_r : y1_r - y0_r;
    steep  = dx_abs < dy_abs;
    a0     = steep ? y0_r : x0_r;
    b0     = steep ? x0_r : y0_r;
    a1     = steep ? y1_r : x1_r;
    b1     = steep ? x1_r : y1_r;
    swap   = a0 > a1;
    maj_s  = swap ? a1 : a0;
    maj_e  = swap ? a0 : a1;
    min_s  = swap ? b1 : b0;
    min_e  = swap ? b0 : b1;
    min_d  = (min_e > min_s) ? min_e - min_s : min_s - min_e;
  end

  // stepping
  logic signed [EW-1:0] err_sum, major_d_s, major_d2_s;
  logic                 minor_move;

  always_comb begin
    major_d_s  = $signed({{(EW-CW){1'b0}}, major_d_r});
    major_d2_s = $signed({{(EW-CW-1){1'b0}}, major_d_r, 1'b0});
    err_sum    = err_r + $signed({{(EW-CW-1){1'b0}}, step_err_r});
    minor_move = err_sum > major_d_s;
  end

  // pixel addressing
  logic [RW-1:0] w_eff, h_eff, row;
  logic [CW-1:0] px, py;
  logic [OW-1:0] prod, lin, offset;
  logic          in_img;

  always_comb begin
    w_eff  = (width_r  > RW'(blr_pkg::MAX_SIDE)) ? RW'(blr_pkg::MAX_SIDE) : width_r;
    h_eff  = (height_r > RW'(blr_pkg::MAX_SIDE)) ? RW'(blr_pkg::MAX_SIDE) : height_r;
    px     = steep_r ? minor_r : major_r;
    py     = steep_r ? major_r : minor_r;
    in_img = ({1'b0, px} < w_eff) && ({1'b0, py} < h_eff);
    row    = h_eff - RW'(1) - {1'b0, py};
    prod   = {{(OW-RW){1'b0}}, row} * {{(OW-RW){1'b0}}, w_eff};
    lin    = prod + {{(OW-CW){1'b0}}, px};
    offset = in_img ? (lin << blr_pkg::BPP_SHIFT) : '0;
  end

  assign sts.out_free = !out_valid_r || !out_stall;
  assign sts.at_last  = (major_r == major_end_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RW'(blr_pkg::MAX_SIDE);
      height_r <= RW'(blr_pkg::MAX_SIDE);
    end else if (cfg_we) begin
      if (cfg_index == blr_pkg::REG_IMAGE_WIDTH)  width_r  <= cfg_data;
      if (cfg_index == blr_pkg::REG_IMAGE_HEIGHT) height_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x0_r    <= in_x_start;
      y0_r    <= in_y_start;
      x1_r    <= in_x_end;
      y1_r    <= in_y_end;
      red_r   <= in_red;
      green_r <= in_green;
      blue_r  <= in_blue;
      alpha_r <= in_alpha;
    end
    if (cmd.setup) begin
      steep_r     <= steep;
      major_r     <= maj_s;
      major_end_r <= maj_e;
      minor_r     <= min_s;
      minor_up_r  <= min_e > min_s;
      major_d_r   <= maj_e - maj_s;
      step_err_r  <= {min_d, 1'b0};
      err_r       <= '0;
    end else if (cmd.step) begin
      major_r <= major_r + CW'(1);
      if (minor_move) begin
        minor_r <= minor_up_r ? minor_r + CW'(1) : minor_r - CW'(1);
        err_r   <= err_sum - major_d2_s;
      end else begin
        err_r   <= err_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.step) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      px_r     <= px;
      py_r     <= py;
      offset_r <= offset;
      ored_r   <= red_r;
      ogreen_r <= green_r;
      oblue_r  <= blue_r;
      oalpha_r <= alpha_r;
      inside_r <= in_img;
      last_r   <= sts.at_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_x     = px_r;
  assign out_pixel_y     = py_r;
  assign out_byte_offset = offset_r;
  assign out_red         = ored_r;
  assign out_green       = ogreen_r;
  assign out_blue        = oblue_r;
  assign out_alpha       = oalpha_r;
  assign out_in_image    = inside_r;
  assign out_last        = last_r;

  `BLR_ASSERT_NEXT(a_major_advances, cmd.step && !sts.at_last,
                   major_r == $past(major_r) + CW'(1), "major axis did not advance")
  `BLR_ASSERT_NEXT(a_step_fills_out, cmd.step, out_valid_r && out_last == $past(sts.at_last),
                   "stepped pixel beat not in output register")
  `BLR_ASSERT_NEXT(a_stalled_beat_held, out_valid_r && out_stall,
                   out_valid_r && $stable(offset_r) && $stable(last_r),
                   "stalled pixel beat changed")

endmodule

[test/line_raster_checker.sv]
// Line rasterizer checker: predicts every pixel beat from the accepted line commands and compares.
module line_raster_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [blr_pkg::COORD_W-1:0]   in_x_start,
  input  logic [blr_pkg::COORD_W-1:0]   in_y_start,
  input  logic [blr_pkg::COORD_W-1:0]   in_x_end,
  input  logic [blr_pkg::COORD_W-1:0]   in_y_end,
  input  logic [blr_pkg::COLOUR_W-1:0]  in_red,
  input  logic [blr_pkg::COLOUR_W-1:0]  in_green,
  input  logic [blr_pkg::COLOUR_W-1:0]  in_blue,
  input  logic [blr_pkg::COLOUR_W-1:0]  in_alpha,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [blr_pkg::COORD_W-1:0]   out_pixel_x,
  input  logic [blr_pkg::COORD_W-1:0]   out_pixel_y,
  input  logic [blr_pkg::OFFS_W-1:0]    out_byte_offset,
  input  logic [blr_pkg::COLOUR_W-1:0]  out_red,
  input  logic [blr_pkg::COLOUR_W-1:0]  out_green,
  input  logic [blr_pkg::COLOUR_W-1:0]  out_blue,
  input  logic [blr_pkg::COLOUR_W-1:0]  out_alpha,
  input  logic                          out_in_image,
  input  logic                          out_last,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [blr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [blr_pkg::CFG_W-1:0]     cfg_data,
  output int unsigned                   fail_count,
  output int unsigned                   pixels_due
);
  timeunit 1ns;
  timeprecision 1ps;
  import blr_pkg::*;

  typedef struct packed {
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic [OFFS_W-1:0]   offset;
    logic [COLOUR_W-1:0] red;
    logic [COLOUR_W-1:0] green;
    logic [COLOUR_W-1:0] blue;
    logic [COLOUR_W-1:0] alpha;
    logic                in_img;
    logic                last;
  } pixel_t;

  pixel_t           pixel_q[$];
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;

  function automatic int span(input int p, input int q);
    return (p > q) ? p - q : q - p;
  endfunction

  function automatic pixel_t make_pixel(input int px, input int py,
                                        input logic [4*COLOUR_W-1:0] rgba, input logic fin);
    pixel_t p;
    int     w;
    int     h;
    w = (width_reg > MAX_SIDE) ? MAX_SIDE : int'(width_reg);
    h = (height_reg > MAX_SIDE) ? MAX_SIDE : int'(height_reg);
    p.x      = px[COORD_W-1:0];
    p.y      = py[COORD_W-1:0];
    p.in_img = (px < w) && (py < h);
    p.offset = p.in_img ? OFFS_W'(((h - 1 - py) * w + px) * BYTES_PER_PIXEL) : '0;
    {p.red, p.green, p.blue, p.alpha} = rgba;
    p.last   = fin;
    return p;
  endfunction

  function automatic void raster_line(input int xs, input int ys, input int xe, input int ye,
                                      input logic [4*COLOUR_W-1:0] rgba);
    int a0, b0, a1, b1, t;
    int major_d, step_err, minor_inc, err, minor;
    bit steep;
    a0 = xs; b0 = ys; a1 = xe; b1 = ye;
    steep = span(a0, a1) < span(b0, b1);
    if (steep) begin
      t = a0; a0 = b0; b0 = t;
      t = a1; a1 = b1; b1 = t;
    end
    if (a0 > a1) begin
      t = a0; a0 = a1; a1 = t;
      t = b0; b0 = b1; b1 = t;
    end
    major_d   = a1 - a0;
    step_err  = span(b1, b0) * 2;
    minor_inc = (b1 > b0) ? 1 : -1;
    err       = 0;
    minor     = b0;
    for (int major = a0; major <= a1; major++) begin
      if (steep) pixel_q.push_back(make_pixel(minor, major, rgba, major == a1));
      else pixel_q.push_back(make_pixel(major, minor, rgba, major == a1));
      err += step_err;
      if (err > major_d) begin
        minor += minor_inc;
        err   -= major_d * 2;
      end
    end
  endfunction

  task automatic note_mismatch(input string what, input pixel_t want, input pixel_t got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t %s: expected x=%0d y=%0d off=%0d rgba=%h in=%b last=%b",
               $time, what, want.x, want.y, want.offset,
               {want.red, want.green, want.blue, want.alpha}, want.in_img, want.last);
      $display("  got x=%0d y=%0d off=%0d rgba=%h in=%b last=%b",
               got.x, got.y, got.offset, {got.red, got.green, got.blue, got.alpha},
               got.in_img, got.last);
    end
  endtask

  always @(posedge clk) begin
    pixel_t got;
    pixel_t want;
    if (!rst_n) begin
      width_reg  = 7'd64;
      height_reg = 7'd64;
      pixel_q.delete();
      pixels_due = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  width_reg  = cfg_data;
          REG_IMAGE_HEIGHT: height_reg = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = '{out_pixel_x, out_pixel_y, out_byte_offset, out_red, out_green, out_blue,
                out_alpha, out_in_image, out_last};
        if (pixel_q.size() == 0) begin
          note_mismatch("pixel beat with none expected", '0, got);
        end else begin
          want = pixel_q.pop_front();
          if (got !== want) note_mismatch("pixel mismatch", want, got);
        end
      end
      if (in_valid && !in_stall)
        raster_line(int'(in_x_start), int'(in_y_start), int'(in_x_end), int'(in_y_end),
                    {in_red, in_green, in_blue, in_alpha});
      pixels_due = pixel_q.size();
    end
  end

endmodule

[test/testbench.sv]
// Top of the line rasterizer testbench: clock, reset, line command and register stimulus, verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import blr_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [COORD_W-1:0]   in_x_start;
  logic [COORD_W-1:0]   in_y_start;
  logic [COORD_W-1:0]   in_x_end;
  logic [COORD_W-1:0]   in_y_end;
  logic [COLOUR_W-1:0]  in_red;
  logic [COLOUR_W-1:0]  in_green;
  logic [COLOUR_W-1:0]  in_blue;
  logic [COLOUR_W-1:0]  in_alpha;
  logic                 out_valid;
  logic                 out_stall;
  logic [COORD_W-1:0]   out_pixel_x;
  logic [COORD_W-1:0]   out_pixel_y;
  logic [OFFS_W-1:0]    out_byte_offset;
  logic [COLOUR_W-1:0]  out_red;
  logic [COLOUR_W-1:0]  out_green;
  logic [COLOUR_W-1:0]  out_blue;
  logic [COLOUR_W-1:0]  out_alpha;
  logic                 out_in_image;
  logic                 out_last;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int unsigned          fail_count;
  int unsigned          pixels_due;
  bit                   sender_idles;
  bit                   receiver_idles;

  bresenham_line_rasterizer_core dut (.*);

  line_raster_checker checker_i (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (receiver_idles && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_line(input logic [COORD_W-1:0] xs, input logic [COORD_W-1:0] ys,
                           input logic [COORD_W-1:0] xe, input logic [COORD_W-1:0] ye,
                           input logic [4*COLOUR_W-1:0] rgba);
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_x_start <= xs;
    in_y_start <= ys;
    in_x_end   <= xe;
    in_y_end   <= ye;
    {in_red, in_green, in_blue, in_alpha} <= rgba;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_lines();
    in_valid <= 1'b0;
    while (pixels_due != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_image(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    drain_lines();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [COORD_W-1:0] near(input int c);
    int v;
    v = c + int'($urandom_range(0, 6)) - 3;
    if (v < 0) v = 0;
    if (v > 63) v = 63;
    return COORD_W'(v);
  endfunction

  function automatic logic [CFG_W-1:0] random_side();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return CFG_W'($urandom_range(65, 127));
    return CFG_W'($urandom_range(1, 64));
  endfunction

  task automatic random_line();
    int unsigned                 kind;
    logic [COORD_W-1:0]          xs, ys, xe, ye;
    logic [4*COLOUR_W-1:0]       rgba;
    kind = $urandom_range(0, 9);
    xs   = COORD_W'($urandom_range(0, 63));
    ys   = COORD_W'($urandom_range(0, 63));
    xe   = COORD_W'($urandom_range(0, 63));
    ye   = COORD_W'($urandom_range(0, 63));
    rgba = $urandom();
    if (kind < 2) begin
      xe = near(int'(xs));
      ye = near(int'(ys));
    end else if (kind == 2) begin
      if ($urandom_range(0, 1)) xe = xs;
      else ye = ys;
    end else if (kind == 3 && $urandom_range(0, 3) == 0) begin
      xe = xs;
      ye = ys;
    end
    send_line(xs, ys, xe, ye, rgba);
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_x_start     = '0;
    in_y_start     = '0;
    in_x_end       = '0;
    in_y_end       = '0;
    in_red         = '0;
    in_green       = '0;
    in_blue        = '0;
    in_alpha       = '0;
    cfg_valid      = 1'b0;
    cfg_index      = REG_IMAGE_WIDTH;
    cfg_data       = '0;
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    set_image(7'd64, 7'd64);
    send_line(6'd0, 6'd0, 6'd0, 6'd0, 32'h0000_0000);
    send_line(6'd63, 6'd63, 6'd63, 6'd63, 32'hffff_ffff);
    send_line(6'd0, 6'd0, 6'd63, 6'd0, 32'h1234_5678);
    send_line(6'd63, 6'd63, 6'd0, 6'd63, 32'haa55_aa55);
    send_line(6'd5, 6'd0, 6'd5, 6'd63, 32'h55aa_55aa);
    send_line(6'd40, 6'd63, 6'd40, 6'd0, 32'hff00_ff00);
    send_line(6'd0, 6'd0, 6'd63, 6'd63, 32'h00ff_00ff);
    send_line(6'd0, 6'd63, 6'd63, 6'd0, 32'h8040_2010);
    send_line(6'd10, 6'd60, 6'd3, 6'd2, 32'h0102_0408);
    send_line(6'd2, 6'd50, 6'd60, 6'd31, 32'hdead_beef);
    send_line(6'd60, 6'd5, 6'd1, 6'd20, 32'hcafe_f00d);
    send_line(6'd31, 6'd32, 6'd32, 6'd31, 32'h7f80_7f80);
    set_image(7'd1, 7'd1);
    send_line(6'd0, 6'd0, 6'd7, 6'd3, 32'h1111_2222);
    set_image(7'd0, 7'd0);
    send_line(6'd3, 6'd3, 6'd20, 6'd9, 32'h3333_4444);
    set_image(7'd127, 7'd100);
    send_line(6'd0, 6'd0, 6'd63, 6'd40, 32'h5555_6666);
    send_line(6'd63, 6'd0, 6'd0, 6'd63, 32'h7777_8888);
    set_image(7'd37, 7'd20);
    send_line(6'd30, 6'd10, 6'd50, 6'd30, 32'h9999_aaaa);
    send_line(6'd0, 6'd25, 6'd45, 6'd0, 32'hbbbb_cccc);

    for (int phase = 0; phase < 5; phase++) begin
      set_image(random_side(), random_side());
      if (phase == 4) begin
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
      end
      repeat (28) random_line();
    end

    drain_lines();
    repeat (12) @(negedge clk);
    if (fail_count == 0 && pixels_due == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
